>>> src/wsm_pkg.sv
// ----------------------------------------------------------------------------
// wsm_pkg - wildcard string matcher shared definitions
// Character codes, configuration register indexes and the control structs
// passed from the top level into the row of matcher cells.
// ----------------------------------------------------------------------------
package wsm_pkg;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int PAT_LEN_W   = 5;
	localparam int BYTE_W      = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

	localparam logic [BYTE_W-1:0] CHAR_STAR     = 8'h2A;
	localparam logic [BYTE_W-1:0] CHAR_PERCENT  = 8'h25;
	localparam logic [BYTE_W-1:0] CHAR_DOT      = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_RBRACKET = 8'h5D;
	localparam logic [BYTE_W-1:0] CHAR_LBRACKET = 8'h5B;

	// per-position pattern decode
	typedef struct packed {
		logic              star;
		logic              percent;
		logic              ell;
		logic              active;
		logic              in_range;
		logic [BYTE_W-1:0] pat_byte;
	} cell_ctl_t;

	// broadcast of the current request to every cell
	typedef struct packed {
		logic              take;
		logic              last;
		logic              b_dot;
		logic              b_rbr;
		logic              prev_ok;
		logic [BYTE_W-1:0] b;
	} step_t;

endpackage

>>> src/wsm_cell.sv
// ----------------------------------------------------------------------------
// wsm_cell - one pattern position of the matcher
// Holds the live, token-start and in-token bits of its position, resolves
// its part of the epsilon closure from its neighbors and computes its
// next state for the current name byte.
// ----------------------------------------------------------------------------
module wsm_cell #(
	parameter logic LIVE_AT_RESET = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wsm_pkg::cell_ctl_t ctl,
	input  wsm_pkg::step_t     step,
	input  logic               star_in,
	input  logic               skip_in,
	input  logic               adv_in,
	output logic               live_c,
	output logic               star_out,
	output logic               skip_out,
	output logic               adv_out
);

	logic live_q;
	logic tok_q;
	logic intok_q;
	logic tok_c;
	logic intok_m;
	logic open_c;
	logic skipping;
	logic live_hit;
	logic nt;
	logic ni;

	assign live_c   = (live_q & ctl.in_range) | star_in | skip_in;
	assign live_hit = live_c & ctl.active;
	assign open_c   = live_hit & ctl.ell & ~ctl.star & ~step.last & ~step.b_dot & step.prev_ok;
	assign tok_c    = (tok_q & ctl.ell) | open_c;
	assign intok_m  = intok_q & ctl.ell;
	assign skip_out = tok_c | (intok_m & (step.last | step.b_rbr));
	assign star_out = live_hit & ctl.star;
	assign adv_out  = live_hit & ~ctl.star & ~ctl.ell &
		(ctl.percent | (ctl.pat_byte == step.b));
	assign skipping = tok_c | intok_m;
	assign nt       = (live_hit & ctl.ell & step.b_dot) | (skipping & step.b_dot);
	assign ni       = skipping & ~step.b_dot & ~step.b_rbr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= LIVE_AT_RESET;
			tok_q   <= 1'b0;
			intok_q <= 1'b0;
		end else if (step.take) begin
			if (step.last) begin
				live_q  <= LIVE_AT_RESET;
				tok_q   <= 1'b0;
				intok_q <= 1'b0;
			end else begin
				live_q  <= star_out | adv_in;
				tok_q   <= nt;
				intok_q <= ni;
			end
		end
	end

endmodule

>>> src/wildcard_string_matcher_core.sv
// ----------------------------------------------------------------------------
// wildcard_string_matcher_core - streaming wildcard name matcher
// Bit-parallel matcher for a configured wildcard pattern with ellipsis,
// built as a row of position cells.
// ----------------------------------------------------------------------------
// The pattern (up to PATTERN_MAX bytes) is written through the configuration
// port while the block is idle. The tested name is then sent one byte per
// request, followed by a request with end_of_name set; only that end request
// produces a result, matched, after which the matcher is ready for the next
// name. The whole row of position cells updates in the cycle the request is
// accepted, so a new request may be sent each clock while in_ready is high.
// The result sits in an output register and does not hold up the input side
// unless it is still waiting to be taken when the next end request arrives.
module wildcard_string_matcher_core #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [wsm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wsm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          name_byte,
	input  logic                                end_of_name,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                matched
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [wsm_pkg::CFG_DATA_W-1:0] pat_low_q;
	logic [wsm_pkg::CFG_DATA_W-1:0] pat_high_q;
	logic [wsm_pkg::PAT_LEN_W-1:0]  pat_len_q;
	logic [7:0]                     prev_byte_q;
	logic                           live_last_q;
	logic                           out_valid_q;
	logic                           matched_q;

	logic [2*wsm_pkg::CFG_DATA_W-1:0] pat_all;
	logic [LEN_W-1:0]                 len;
	logic [PATTERN_MAX-1:0]           dot;
	logic [PATTERN_MAX-1:0]           star_v;
	logic [PATTERN_MAX-1:0]           skip_v;
	logic [PATTERN_MAX-1:0]           adv_v;
	logic [PATTERN_MAX:0]             live_v;
	logic                             accept;
	wsm_pkg::step_t                   step;
	wsm_pkg::cell_ctl_t               ctl [PATTERN_MAX];

	assign pat_all  = {pat_high_q, pat_low_q};
	assign len      = (int'(pat_len_q) > PATTERN_MAX) ?
		LEN_W'(PATTERN_MAX) : pat_len_q[LEN_W-1:0];
	// only an end request needs the output register free
	assign in_ready = ~out_valid_q | out_ready | ~end_of_name;
	assign accept   = in_valid & in_ready;

	assign step.take    = accept;
	assign step.last    = end_of_name;
	assign step.b       = name_byte;
	assign step.b_dot   = (name_byte == wsm_pkg::CHAR_DOT);
	assign step.b_rbr   = (name_byte == wsm_pkg::CHAR_RBRACKET);
	assign step.prev_ok = (prev_byte_q == wsm_pkg::CHAR_DOT) ||
		(prev_byte_q == wsm_pkg::CHAR_LBRACKET);

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [7:0] pb;
		logic       star_in;
		logic       skip_in;
		logic       adv_in;

		assign pb     = pat_all[8*i +: 8];
		assign dot[i] = (pb == wsm_pkg::CHAR_DOT);

		assign ctl[i].pat_byte = pb;
		assign ctl[i].star     = (pb == wsm_pkg::CHAR_STAR);
		assign ctl[i].percent  = (pb == wsm_pkg::CHAR_PERCENT);
		assign ctl[i].active   = (LEN_W'(i) < len);
		assign ctl[i].in_range = (LEN_W'(i) <= len);

		if (i + 2 < PATTERN_MAX) begin : g_ell
			assign ctl[i].ell = (LEN_W'(i + 2) < len) & dot[i] & dot[i+1] & dot[i+2];
		end else begin : g_no_ell
			assign ctl[i].ell = 1'b0;
		end

		if (i > 0) begin : g_prev
			assign star_in = star_v[i-1];
			assign adv_in  = adv_v[i-1];
		end else begin : g_first
			assign star_in = 1'b0;
			assign adv_in  = 1'b0;
		end

		if (i >= 3) begin : g_skip
			assign skip_in = skip_v[i-3];
		end else begin : g_no_skip
			assign skip_in = 1'b0;
		end

		wsm_cell #(
			.LIVE_AT_RESET((i == 0) ? 1'b1 : 1'b0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[i]),
			.step     (step),
			.star_in  (star_in),
			.skip_in  (skip_in),
			.adv_in   (adv_in),
			.live_c   (live_v[i]),
			.star_out (star_v[i]),
			.skip_out (skip_v[i]),
			.adv_out  (adv_v[i])
		);
	end

	// final position, past the last cell
	assign live_v[PATTERN_MAX] = (live_last_q & (len == LEN_W'(PATTERN_MAX))) |
		star_v[PATTERN_MAX-1] | skip_v[PATTERN_MAX-3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				wsm_pkg::CFG_PATTERN_LOW:  pat_low_q  <= cfg_data;
				wsm_pkg::CFG_PATTERN_HIGH: pat_high_q <= cfg_data;
				wsm_pkg::CFG_PATTERN_LEN:  pat_len_q  <= cfg_data[wsm_pkg::PAT_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q <= '0;
			live_last_q <= 1'b0;
		end else if (accept) begin
			if (end_of_name) begin
				prev_byte_q <= '0;
				live_last_q <= 1'b0;
			end else begin
				prev_byte_q <= name_byte;
				live_last_q <= adv_v[PATTERN_MAX-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && end_of_name) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_name) begin
			matched_q <= live_v[len];
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_name) |=> out_valid)
		else $error("end request did not produce a result");

	a_byte_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !end_of_name && !out_valid_q) |=> !out_valid)
		else $error("byte request produced a result");

	a_end_clears_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_name) |=> (prev_byte_q == 8'd0) && !live_last_q)
		else $error("name state not cleared after end request");

	a_end_restarts_live: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_name) |=> live_v[0])
		else $error("start position not live after end request");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - wildcard string matcher core
// Loads wildcard patterns through the configuration port and streams names
// into the core one byte per request, each closed by an end request. A
// scoreboard runs its own bit-parallel model of the pattern positions and
// checks every matched result in order. Directed names cover the ellipsis and
// other corner cases; random phases then build names from each random pattern,
// with some mutated and some pure noise. Both sides idle at random, except in phases 8 to 13.
// ----------------------------------------------------------------------------

class match_scoreboard #(int PAT_MAX = 16);
	logic [63:0] pat_lo;
	logic [63:0] pat_hi;
	logic [4:0]  pat_len_reg;
	logic [31:0] live_st;
	logic [31:0] tok_st;
	logic [31:0] intok_st;
	logic [7:0]  prev_b;
	bit          match_q[$];
	int          errors;
	int          results;
	int          hits;
	int          items;

	function new();
		pat_lo = '0;
		pat_hi = '0;
		pat_len_reg = '0;
		errors = 0;
		results = 0;
		hits = 0;
		items = 0;
		clear_name();
	endfunction

	function void clear_name();
		live_st = 32'd1;
		tok_st = '0;
		intok_st = '0;
		prev_b = '0;
	endfunction

	function void set_pattern(logic [127:0] p, logic [4:0] len);
		pat_lo = p[63:0];
		pat_hi = p[127:64];
		pat_len_reg = len;
	endfunction

	function int eff_len();
		return (pat_len_reg > PAT_MAX) ? PAT_MAX : int'(pat_len_reg);
	endfunction

	function logic [7:0] pbyte(int i);
		if (i < 8)
			return pat_lo[8*i +: 8];
		if (i < 16)
			return pat_hi[8*(i-8) +: 8];
		return 8'h00;
	endfunction

	function bit is_ell(int i, int len);
		return (i + 2 < len) && pbyte(i) == wsm_pkg::CHAR_DOT &&
			pbyte(i + 1) == wsm_pkg::CHAR_DOT && pbyte(i + 2) == wsm_pkg::CHAR_DOT;
	endfunction

	// advance the position sets by one request
	function void note_request(logic [7:0] b, bit eon);
		int          len;
		logic [31:0] ell;
		logic [31:0] live;
		logic [31:0] tok;
		logic [31:0] intok;
		logic [31:0] nl;
		logic [31:0] nt;
		logic [31:0] ni;
		logic [7:0]  c;
		bit          prev_ok;
		len = eff_len();
		ell = '0;
		nl = '0;
		nt = '0;
		ni = '0;
		items++;
		for (int i = 0; i < len; i++)
			if (is_ell(i, len))
				ell[i] = 1'b1;
		live = live_st & ((32'd1 << (len + 1)) - 32'd1);
		tok = tok_st & ell;
		intok = intok_st & ell;
		prev_ok = (prev_b == wsm_pkg::CHAR_DOT) || (prev_b == wsm_pkg::CHAR_LBRACKET);

		// closure over empty moves at this name index
		for (int i = 0; i <= len; i++) begin
			if (live[i] && i < len) begin
				if (pbyte(i) == wsm_pkg::CHAR_STAR)
					live[i+1] = 1'b1;
				else if (ell[i] && !eon && b != wsm_pkg::CHAR_DOT && prev_ok)
					tok[i] = 1'b1;
			end
			if (tok[i])
				live[i+3] = 1'b1;
			if (intok[i] && (eon || b == wsm_pkg::CHAR_RBRACKET))
				live[i+3] = 1'b1;
		end

		if (eon) begin
			match_q.push_back(live[len]);
			clear_name();
			return;
		end

		for (int i = 0; i < len; i++) begin
			if (live[i]) begin
				c = pbyte(i);
				if (c == wsm_pkg::CHAR_STAR)
					nl[i] = 1'b1;
				else if (ell[i]) begin
					if (b == wsm_pkg::CHAR_DOT)
						nt[i] = 1'b1;
				end else if (c == wsm_pkg::CHAR_PERCENT || c == b)
					nl[i+1] = 1'b1;
			end
			if (tok[i] || intok[i]) begin
				if (b == wsm_pkg::CHAR_DOT)
					nt[i] = 1'b1;
				else if (b != wsm_pkg::CHAR_RBRACKET)
					ni[i] = 1'b1;
			end
		end
		live_st = nl;
		tok_st = nt;
		intok_st = ni;
		prev_b = b;
	endfunction

	function void check_result(logic m);
		bit want;
		results++;
		if (m === 1'b1)
			hits++;
		if (match_q.size() == 0) begin
			errors++;
			$display("%0t: result with none expected: expected none, actual %0b", $time, m);
			return;
		end
		want = match_q.pop_front();
		if (m !== want) begin
			errors++;
			$display("%0t: matched mismatch: expected %0b, actual %0b", $time, want, m);
		end
	endfunction

	function int pending();
		return match_q.size();
	endfunction
endclass

module testbench;
	localparam int PATTERN_MAX  = 16;
	localparam int RANDOM_ITEMS = 1350;
	localparam int CYCLE_LIMIT  = 300000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_write_en = 1'b0;
	logic [wsm_pkg::CFG_IDX_W-1:0]  cfg_index = wsm_pkg::CFG_PATTERN_LOW;
	logic [wsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [7:0]                     name_byte = '0;
	logic                           end_of_name = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           matched;

	match_scoreboard #(PATTERN_MAX) sb;
	logic [7:0] name_buf[$];
	int         idle_pct = 29;
	int         cycles = 0;
	int         phases = 0;
	int         names = 0;

	wildcard_string_matcher_core #(
		.PATTERN_MAX(PATTERN_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.name_byte(name_byte),
		.end_of_name(end_of_name),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched(matched)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("wildcard_string_matcher_core test failed");
			$finish;
		end
	end

	// result side: check accepted results, then pick next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(matched);
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	function automatic logic [7:0] rand_char();
		case ($urandom_range(9))
			0, 1: return 8'h61;
			2: return 8'h62;
			3, 4: return wsm_pkg::CHAR_DOT;
			5: return wsm_pkg::CHAR_LBRACKET;
			6: return wsm_pkg::CHAR_RBRACKET;
			7: return 8'h00;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [127:0] pack_str(string s);
		logic [127:0] v;
		v = '0;
		for (int i = 0; i < s.len() && i < 16; i++)
			v[8*i +: 8] = s[i];
		return v;
	endfunction

	task automatic send_item(logic [7:0] b, bit eon);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		name_byte <= b;
		end_of_name <= eon;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(b, eon);
	endtask

	task automatic send_name();
		foreach (name_buf[i])
			send_item(name_buf[i], 1'b0);
		send_item(8'($urandom_range(255)), 1'b1);
		names++;
	endtask

	task automatic send_str(string s);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++)
			name_buf.push_back(s[i]);
		send_name();
	endtask

	// drain outstanding results before touching the pattern
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pattern(logic [127:0] p, logic [4:0] len);
		cfg_write_en <= 1'b1;
		cfg_index <= wsm_pkg::CFG_PATTERN_LOW;
		cfg_data <= p[63:0];
		@(posedge clk);
		cfg_index <= wsm_pkg::CFG_PATTERN_HIGH;
		cfg_data <= p[127:64];
		@(posedge clk);
		cfg_index <= wsm_pkg::CFG_PATTERN_LEN;
		cfg_data <= {{(wsm_pkg::CFG_DATA_W-5){1'b0}}, len};
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sb.set_pattern(p, len);
		phases++;
	endtask

	task automatic random_pattern();
		logic [127:0] p;
		logic [4:0]   len;
		int           n;
		int           target;
		p = {$urandom, $urandom, $urandom, $urandom};
		n = 0;
		target = $urandom_range(PATTERN_MAX);
		while (n < target) begin
			case ($urandom_range(9))
				0, 1: begin p[8*n +: 8] = 8'h61; n++; end
				2: begin p[8*n +: 8] = wsm_pkg::CHAR_DOT; n++; end
				3: begin
					p[8*n +: 8] = $urandom_range(1) ?
						wsm_pkg::CHAR_LBRACKET : wsm_pkg::CHAR_RBRACKET;
					n++;
				end
				4, 5: begin p[8*n +: 8] = wsm_pkg::CHAR_STAR; n++; end
				6: begin p[8*n +: 8] = wsm_pkg::CHAR_PERCENT; n++; end
				7, 8: begin
					if (n + 3 <= PATTERN_MAX) begin
						p[8*n +: 24] = {wsm_pkg::CHAR_DOT, wsm_pkg::CHAR_DOT,
							wsm_pkg::CHAR_DOT};
						n += 3;
					end
				end
				default: begin p[8*n +: 8] = 8'($urandom_range(255)); n++; end
			endcase
		end
		len = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'(n);
		write_pattern(p, len);
	endtask

	// a name shaped by the loaded pattern, sometimes mutated, sometimes noise
	task automatic random_name();
		int          i;
		int          n;
		int          k;
		int          len;
		logic [7:0]  c;
		name_buf.delete();
		len = sb.eff_len();
		if ($urandom_range(99) < 15) begin
			n = $urandom_range(8);
			repeat (n) name_buf.push_back(rand_char());
		end else begin
			i = 0;
			while (i < len) begin
				c = sb.pbyte(i);
				if (sb.is_ell(i, len)) begin
					case ($urandom_range(2))
						0: name_buf.push_back(wsm_pkg::CHAR_DOT);
						1: ;
						default: begin
							n = $urandom_range(1, 2);
							repeat (n) begin
								k = $urandom_range(2);
								repeat (k) name_buf.push_back(8'h61 + 8'($urandom_range(1)));
								name_buf.push_back(wsm_pkg::CHAR_DOT);
							end
						end
					endcase
					i += 3;
				end else begin
					if (c == wsm_pkg::CHAR_STAR) begin
						n = $urandom_range(3);
						repeat (n) name_buf.push_back(rand_char());
					end else if (c == wsm_pkg::CHAR_PERCENT)
						name_buf.push_back(rand_char());
					else
						name_buf.push_back(c);
					i++;
				end
			end
			if ($urandom_range(99) < 20) begin
				if (name_buf.size() > 0 && $urandom_range(1))
					name_buf[$urandom_range(name_buf.size() - 1)] = rand_char();
				else
					name_buf.push_back(rand_char());
			end
		end
		send_name();
	endtask

	initial begin
		int wait_cycles;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ellipsis inside brackets
		write_pattern(pack_str("[...]"), 5'd5);
		send_str("[a.b]");
		send_str("[]");
		// bare ellipsis: empty name, start of name, token cut by end
		settle();
		write_pattern(pack_str("..."), 5'd3);
		send_str("");
		send_str("x");
		send_str(".ab");
		// dots too close to the end are literal
		settle();
		write_pattern(pack_str("a.."), 5'd3);
		send_str("a..");
		// zero bytes in pattern and name
		settle();
		write_pattern({112'h0, wsm_pkg::CHAR_PERCENT, 8'h00}, 5'd2);
		name_buf.delete();
		name_buf.push_back(8'h00);
		name_buf.push_back(8'hFF);
		send_name();
		// trailing star on an exhausted name
		settle();
		write_pattern(pack_str("a*"), 5'd2);
		send_str("a");

		for (int ph = 0; sb.items < RANDOM_ITEMS + 25; ph++) begin
			idle_pct = (ph >= 8 && ph < 14) ? 0 : 29;
			settle();
			case (ph)
				0: write_pattern({128{1'b1}}, 5'd31);
				1: write_pattern('0, 5'd16);
				2: write_pattern({$urandom, $urandom, $urandom, $urandom}, 5'd0);
				default: random_pattern();
			endcase
			repeat ($urandom_range(4, 10)) random_name();
		end

		in_valid <= 1'b0;
		wait_cycles = 0;
		while (sb.pending() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d results never arrived", $time, sb.pending());
		end
		$display("ran %0d patterns and %0d names in %0d requests", phases, names, sb.items);
		$display("checked %0d results, %0d of them matches, %0d errors",
			sb.results, sb.hits, sb.errors);
		if (sb.errors == 0)
			$display("wildcard_string_matcher_core test passed");
		else
			$display("wildcard_string_matcher_core test failed");
		$finish;
	end
endmodule
